// ===== rtl/core/elev_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package elev_pkg;

    typedef enum logic [1:0] {
        DOOR_SHUT     = 2'd0,
        DOOR_PARTING  = 2'd1,
        DOOR_WIDE     = 2'd2,
        DOOR_SHUTTING = 2'd3
    } t_door;

    typedef enum logic [1:0] {
        DIR_IDLE = 2'd0,
        DIR_UP   = 2'd1,
        DIR_DOWN = 2'd2
    } t_dir;

    typedef logic [3:0] t_floor;
    typedef logic [4:0] t_ticks;

    localparam logic [1:0] CFG_DOOR_MOTION = 2'd0;
    localparam logic [1:0] CFG_DOOR_HOLD   = 2'd1;
    localparam logic [1:0] CFG_TRAVEL      = 2'd2;
    localparam logic [1:0] CFG_TOP_FLOOR   = 2'd3;

    localparam t_ticks RST_DOOR_MOTION = 5'd5;
    localparam t_ticks RST_DOOR_HOLD   = 5'd15;
    localparam t_ticks RST_TRAVEL      = 5'd10;
    localparam t_floor RST_TOP_FLOOR   = 4'd8;
    localparam t_floor BOTTOM_FLOOR    = 4'd1;

endpackage

`default_nettype wire

// ===== rtl/core/elevator_door_and_travel_controller.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Elevator door and travel controller. Each input transfer is one tick and
// produces exactly one result transfer. A tick is taken every clock cycle
// while the result side keeps up; its result is registered once the tick has
// passed from the input register through a single pass of logic into the
// result register, and a stalled result holds the input side off.
// Configuration writes are taken at any time but are meant to be made while
// no tick is in flight.

module elevator_door_and_travel_controller
    import elev_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [7:0]  i_s_axis_tdata,   // [3:0] req_floor, [7:4] zero
    input  wire logic        i_s_axis_tuser,   // [0] has_request
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    // [0] request_taken, [4:1] floor_now, [8:5] floor_goal, [10:9] direction,
    // [11] in_motion, [13:12] door_state, [15:14] zero
    output logic [15:0]      o_m_axis_tdata,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [4:0]  i_cfg_data
);

    t_ticks r_motion_ticks;
    t_ticks r_hold_ticks;
    t_ticks r_travel_ticks;
    t_floor r_top_floor;

    logic   r_in_valid;
    logic   r_in_has;
    t_floor r_in_floor;
    logic   r_out_valid;
    logic [15:0] r_out_data;

    t_floor r_car;
    t_floor r_goal;
    t_dir   r_dir;
    logic   r_moving;
    t_door  r_door;
    t_ticks r_timer;
    t_ticks r_travel_count;

    t_floor n_car;
    t_floor n_goal;
    t_dir   n_dir;
    logic   n_moving;
    t_door  n_door;
    t_ticks n_timer;
    t_ticks n_travel_count;
    logic   n_taken;

    logic   w_advance;
    logic   w_valid_req;
    t_door  w_door_req;
    logic [5:0] w_next_count;

    assign w_advance       = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || w_advance;
    assign o_cfg_ready     = 1'b1;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

    assign w_valid_req  = r_in_has && (r_in_floor != 4'd0) && (r_in_floor <= r_top_floor);
    assign w_next_count = {1'b0, r_travel_count} + 6'd1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_motion_ticks <= RST_DOOR_MOTION;
            r_hold_ticks   <= RST_DOOR_HOLD;
            r_travel_ticks <= RST_TRAVEL;
            r_top_floor    <= RST_TOP_FLOOR;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_DOOR_MOTION: r_motion_ticks <= i_cfg_data;
                CFG_DOOR_HOLD:   r_hold_ticks   <= i_cfg_data;
                CFG_TRAVEL:      r_travel_ticks <= i_cfg_data;
                CFG_TOP_FLOOR:   r_top_floor    <= i_cfg_data[3:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_s_axis_tready) begin
                r_in_valid <= i_s_axis_tvalid;
            end
            if (w_advance) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in_has   <= i_s_axis_tuser;
            r_in_floor <= i_s_axis_tdata[3:0];
        end
        if (w_advance) begin
            r_out_data <= {2'b00, n_door, n_moving, n_dir, n_goal, n_car, n_taken};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_car          <= BOTTOM_FLOOR;
            r_goal         <= BOTTOM_FLOOR;
            r_dir          <= DIR_IDLE;
            r_moving       <= 1'b0;
            r_door         <= DOOR_SHUT;
            r_timer        <= 5'd0;
            r_travel_count <= 5'd0;
        end else if (w_advance) begin
            r_car          <= n_car;
            r_goal         <= n_goal;
            r_dir          <= n_dir;
            r_moving       <= n_moving;
            r_door         <= n_door;
            r_timer        <= n_timer;
            r_travel_count <= n_travel_count;
        end
    end

    always_comb begin
        n_taken        = w_valid_req;
        n_car          = r_car;
        n_goal         = r_goal;
        n_dir          = r_dir;
        n_moving       = r_moving;
        n_timer        = r_timer;
        n_travel_count = r_travel_count;
        w_door_req     = r_door;

        if (w_valid_req) begin
            n_goal = r_in_floor;
            if (r_door == DOOR_WIDE || r_door == DOOR_PARTING) begin
                w_door_req = DOOR_SHUTTING;
                n_timer    = r_motion_ticks;
            end else if (r_door == DOOR_SHUT) begin
                n_moving = (r_in_floor != r_car);
                if (r_in_floor > r_car) begin
                    n_dir = DIR_UP;
                end else if (r_in_floor < r_car) begin
                    n_dir = DIR_DOWN;
                end else begin
                    n_dir = DIR_IDLE;
                end
            end
        end

        n_door = w_door_req;
        case (w_door_req)
            DOOR_SHUTTING: begin
                if (n_timer > 5'd1) begin
                    n_timer = n_timer - 5'd1;
                end else begin
                    n_timer  = 5'd0;
                    n_door   = DOOR_SHUT;
                    n_moving = (n_goal != r_car);
                    if (n_goal > r_car) begin
                        n_dir = DIR_UP;
                    end else if (n_goal < r_car) begin
                        n_dir = DIR_DOWN;
                    end else begin
                        n_dir = DIR_IDLE;
                    end
                end
            end
            DOOR_PARTING: begin
                if (n_timer > 5'd1) begin
                    n_timer = n_timer - 5'd1;
                end else begin
                    n_door  = DOOR_WIDE;
                    n_timer = r_hold_ticks;
                end
            end
            DOOR_WIDE: begin
                if (n_timer > 5'd1) begin
                    n_timer = n_timer - 5'd1;
                end else begin
                    n_door  = DOOR_SHUTTING;
                    n_timer = r_motion_ticks;
                end
            end
            default: begin
                if (n_moving && n_dir != DIR_IDLE) begin
                    if (w_next_count >= {1'b0, r_travel_ticks}) begin
                        n_travel_count = 5'd0;
                        if (n_dir == DIR_UP && r_car < r_top_floor) begin
                            n_car = r_car + 4'd1;
                        end else if (n_dir == DIR_DOWN && r_car > BOTTOM_FLOOR) begin
                            n_car = r_car - 4'd1;
                        end
                        if (n_car == n_goal) begin
                            n_dir    = DIR_IDLE;
                            n_moving = 1'b0;
                            n_door   = DOOR_PARTING;
                            n_timer  = r_motion_ticks;
                        end
                    end else begin
                        n_travel_count = w_next_count[4:0];
                    end
                end else begin
                    n_travel_count = 5'd0;
                end
            end
        endcase
    end

`ifndef SYNTH
    a_moving_door_closed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_moving |-> (r_door == DOOR_SHUT))
        else $error("car marked as moving with the door not closed");

    a_dir_matches_moving: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_moving == (r_dir != DIR_IDLE))
        else $error("direction and moving flag disagree");

    a_car_never_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_car != 4'd0)
        else $error("car floor left the valid range");

    a_request_sets_goal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_advance && w_valid_req) |=> (r_goal == $past(r_in_floor)))
        else $error("accepted request did not replace the target floor");
`endif

endmodule

`default_nettype wire

// ===== tb/elevator_result_checker.sv =====
`timescale 1ns / 1ps

module elevator_result_checker
    import elev_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    input  wire logic        i_s_axis_tready,
    input  wire logic [7:0]  i_s_axis_tdata,   // [3:0] req_floor, [7:4] zero
    input  wire logic        i_s_axis_tuser,   // [0] has_request
    input  wire logic        i_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    // [0] request_taken, [4:1] floor_now, [8:5] floor_goal, [10:9] direction,
    // [11] in_motion, [13:12] door_state, [15:14] zero
    input  wire logic [15:0] i_m_axis_tdata,
    input  wire logic        i_cfg_valid,
    input  wire logic        i_cfg_ready,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [4:0]  i_cfg_data,
    output int               o_fail_count,
    output int               o_pending,
    output int               o_results_seen,
    output int               o_requests_taken,
    output int               o_arrivals
);

    typedef struct packed {
        logic   taken;
        t_floor now;
        t_floor goal;
        t_dir   dir;
        logic   moving;
        t_door  door;
    } t_car_status;

    t_ticks motion_ticks;
    t_ticks hold_ticks;
    t_ticks travel_period;
    t_floor top_floor_cfg;

    t_floor car_at;
    t_floor car_goal;
    t_dir   heading;
    logic   set_to_move;
    t_door  door_now;
    t_ticks door_count;
    t_ticks travel_count;

    t_car_status expected_status_q[$];

    int fail_count = 0;
    int pending_count = 0;
    int results_seen = 0;
    int requests_taken = 0;
    int arrival_count = 0;

    assign o_fail_count     = fail_count;
    assign o_pending        = pending_count;
    assign o_results_seen   = results_seen;
    assign o_requests_taken = requests_taken;
    assign o_arrivals       = arrival_count;

    task automatic report_mismatch(input string field, input logic [15:0] got,
                                   input logic [15:0] want);
        if (fail_count < 30) begin
            $display("MISMATCH result %0d %s: got 0x%0h, expected 0x%0h",
                     results_seen, field, got, want);
        end
        fail_count++;
    endtask

    function automatic void aim_car();
        if (car_goal > car_at) begin
            heading = DIR_UP;
            set_to_move = 1'b1;
        end else if (car_goal < car_at) begin
            heading = DIR_DOWN;
            set_to_move = 1'b1;
        end else begin
            heading = DIR_IDLE;
            set_to_move = 1'b0;
        end
    endfunction

    // A door phase ends once its timer has run down to one or was loaded with zero.
    function automatic logic door_phase_done();
        if (door_count > 5'd1) begin
            door_count = door_count - 5'd1;
            return 1'b0;
        end
        door_count = '0;
        return 1'b1;
    endfunction

    function automatic t_car_status advance_car_tick(input logic has_req, input t_floor req);
        t_car_status st;
        logic        taken;
        int          nxt;
        taken = has_req && (req >= BOTTOM_FLOOR) && (req <= top_floor_cfg);
        if (taken) begin
            requests_taken++;
            car_goal = req;
            if (door_now == DOOR_WIDE || door_now == DOOR_PARTING) begin
                door_now = DOOR_SHUTTING;
                door_count = motion_ticks;
            end else if (door_now == DOOR_SHUT) begin
                aim_car();
            end
        end
        case (door_now)
            DOOR_SHUTTING: begin
                if (door_phase_done()) begin
                    door_now = DOOR_SHUT;
                    aim_car();
                end
            end
            DOOR_PARTING: begin
                if (door_phase_done()) begin
                    door_now = DOOR_WIDE;
                    door_count = hold_ticks;
                end
            end
            DOOR_WIDE: begin
                if (door_phase_done()) begin
                    door_now = DOOR_SHUTTING;
                    door_count = motion_ticks;
                end
            end
            default: begin
                if (set_to_move && heading != DIR_IDLE) begin
                    nxt = int'(travel_count) + 1;
                    if (nxt >= int'(travel_period)) begin
                        travel_count = '0;
                        if (heading == DIR_UP && car_at < top_floor_cfg) begin
                            car_at = car_at + 4'd1;
                        end else if (heading == DIR_DOWN && car_at > BOTTOM_FLOOR) begin
                            car_at = car_at - 4'd1;
                        end
                        if (car_at == car_goal) begin
                            heading = DIR_IDLE;
                            set_to_move = 1'b0;
                            door_now = DOOR_PARTING;
                            door_count = motion_ticks;
                            arrival_count++;
                        end
                    end else begin
                        travel_count = t_ticks'(nxt);
                    end
                end else begin
                    travel_count = '0;
                end
            end
        endcase
        st.taken  = taken;
        st.now    = car_at;
        st.goal   = car_goal;
        st.dir    = heading;
        st.moving = set_to_move;
        st.door   = door_now;
        return st;
    endfunction

    always @(posedge i_clk) begin : watch
        t_car_status want;
        logic [15:0] got;
        if (!i_rst_n) begin
            motion_ticks  = RST_DOOR_MOTION;
            hold_ticks    = RST_DOOR_HOLD;
            travel_period = RST_TRAVEL;
            top_floor_cfg = RST_TOP_FLOOR;
            car_at        = BOTTOM_FLOOR;
            car_goal      = BOTTOM_FLOOR;
            heading       = DIR_IDLE;
            set_to_move   = 1'b0;
            door_now      = DOOR_SHUT;
            door_count    = '0;
            travel_count  = '0;
            expected_status_q.delete();
            pending_count = 0;
        end else begin
            if (i_m_axis_tvalid && i_m_axis_tready) begin
                got = i_m_axis_tdata;
                if (expected_status_q.size() == 0) begin
                    report_mismatch("result with nothing expected", got, '0);
                end else begin
                    want = expected_status_q.pop_front();
                    pending_count--;
                    if (got[0] !== want.taken) begin
                        report_mismatch("request_taken", got[0], want.taken);
                    end
                    if (got[4:1] !== want.now) begin
                        report_mismatch("floor_now", got[4:1], want.now);
                    end
                    if (got[8:5] !== want.goal) begin
                        report_mismatch("floor_goal", got[8:5], want.goal);
                    end
                    if (got[10:9] !== want.dir) begin
                        report_mismatch("direction", got[10:9], want.dir);
                    end
                    if (got[11] !== want.moving) begin
                        report_mismatch("in_motion", got[11], want.moving);
                    end
                    if (got[13:12] !== want.door) begin
                        report_mismatch("door_state", got[13:12], want.door);
                    end
                    if (got[15:14] !== 2'b00) begin
                        report_mismatch("padding", got[15:14], '0);
                    end
                end
                results_seen++;
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_DOOR_MOTION: motion_ticks  = i_cfg_data;
                    CFG_DOOR_HOLD:   hold_ticks    = i_cfg_data;
                    CFG_TRAVEL:      travel_period = i_cfg_data;
                    CFG_TOP_FLOOR:   top_floor_cfg = i_cfg_data[3:0];
                    default: ;
                endcase
            end
            if (i_s_axis_tvalid && i_s_axis_tready) begin
                expected_status_q.push_back(
                    advance_car_tick(i_s_axis_tuser, i_s_axis_tdata[3:0]));
                pending_count++;
            end
        end
    end

endmodule

// ===== tb/tb_elevator_door_and_travel_controller.sv =====
`timescale 1ns / 1ps

module tb_elevator_door_and_travel_controller;
    import elev_pkg::*;

    localparam int IDLE_LIMIT      = 3000;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int RANDOM_PHASES   = 8;
    localparam int PHASE_TICKS     = 100;

    // Each entry is {has_request, req_floor}.
    localparam logic [4:0] WARMUP_TICKS [18] = '{
        5'h00, 5'h10, 5'h11, 5'h13, 5'h0F, 5'h15, 5'h12, 5'h00, 5'h00,
        5'h00, 5'h00, 5'h00, 5'h1F, 5'h00, 5'h00, 5'h00, 5'h00, 5'h00
    };
    localparam logic [4:0] LOW_TOP_TICKS [10] = '{
        5'h00, 5'h07, 5'h13, 5'h10, 5'h12, 5'h00, 5'h00, 5'h00, 5'h11, 5'h00
    };

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = '0;
    logic        s_tuser   = 1'b0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [15:0] m_tdata;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = CFG_DOOR_MOTION;
    logic [4:0]  cfg_data  = '0;

    int fail_count;
    int pending;
    int results_seen;
    int requests_taken;
    int arrivals;
    int settings_written = 0;
    int stall_cycles = 0;

    always #5 clk = ~clk;

    elevator_door_and_travel_controller DUT (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    elevator_result_checker u_checker (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_s_axis_tvalid  (s_tvalid),
        .i_s_axis_tready  (s_tready),
        .i_s_axis_tdata   (s_tdata),
        .i_s_axis_tuser   (s_tuser),
        .i_m_axis_tvalid  (m_tvalid),
        .i_m_axis_tready  (m_tready),
        .i_m_axis_tdata   (m_tdata),
        .i_cfg_valid      (cfg_valid),
        .i_cfg_ready      (cfg_ready),
        .i_cfg_index      (cfg_index),
        .i_cfg_data       (cfg_data),
        .o_fail_count     (fail_count),
        .o_pending        (pending),
        .o_results_seen   (results_seen),
        .o_requests_taken (requests_taken),
        .o_arrivals       (arrivals)
    );

    task automatic send_tick(input logic has_req, input t_floor flr);
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tuser  <= has_req;
        s_tdata  <= {4'd0, flr};
        do @(posedge clk); while (!s_tready);
    endtask

    task automatic pause_ticks(input int n);
        @(negedge clk);
        s_tvalid <= 1'b0;
        repeat (n - 1) @(negedge clk);
    endtask

    // Waits until every tick has produced its result, then lets the pipeline settle.
    task automatic drain_results();
        pause_ticks(1);
        while (pending != 0) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_config(input t_ticks motion, input t_ticks hold,
                                input t_ticks travel, input t_floor top);
        logic [1:0] regs [4];
        t_ticks     vals [4];
        regs = '{CFG_DOOR_MOTION, CFG_DOOR_HOLD, CFG_TRAVEL, CFG_TOP_FLOOR};
        vals = '{motion, hold, travel, {1'b0, top}};
        for (int r = 0; r < 4; r++) begin
            @(negedge clk);
            cfg_valid <= 1'b1;
            cfg_index <= regs[r];
            cfg_data  <= vals[r];
            do @(posedge clk); while (!cfg_ready);
        end
        @(negedge clk);
        cfg_valid <= 1'b0;
        settings_written++;
    endtask

    // Timing registers are mostly in range, with zero now and then.
    function automatic t_ticks rand_period();
        if ($urandom_range(0, 7) == 0) begin
            return 5'd0;
        end
        return t_ticks'($urandom_range(1, 31));
    endfunction

    initial begin : stimulus
        int     burst_left;
        int     req_pct;
        int     pick;
        t_floor top_now;
        t_floor flr;
        logic   has_req;
        burst_left = 0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Fast doors with a zero travel period, so the car steps on every tick.
        write_config(5'd2, 5'd2, 5'd0, 4'd15);
        foreach (WARMUP_TICKS[k]) begin
            send_tick(WARMUP_TICKS[k][4], WARMUP_TICKS[k][3:0]);
        end
        drain_results();

        // The car is now above the new top floor and is held there while marked moving.
        write_config(5'd0, 5'd0, 5'd1, 4'd2);
        foreach (LOW_TOP_TICKS[k]) begin
            send_tick(LOW_TOP_TICKS[k][4], LOW_TOP_TICKS[k][3:0]);
        end
        drain_results();

        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            case (phase)
                0: begin
                    top_now = 4'd15;
                    write_config(5'd1, 5'd1, 5'd1, top_now);
                end
                1: begin
                    top_now = 4'd15;
                    write_config(5'd31, 5'd31, 5'd31, top_now);
                end
                2: begin
                    top_now = 4'd2;
                    write_config(rand_period(), rand_period(), rand_period(), top_now);
                end
                default: begin
                    top_now = t_floor'($urandom_range(2, 15));
                    write_config(rand_period(), rand_period(), rand_period(), top_now);
                end
            endcase
            case ($urandom_range(0, 2))
                0: req_pct = 3;
                1: req_pct = 10;
                default: req_pct = 35;
            endcase
            if (phase == 1) begin
                req_pct = 3;
            end
            for (int n = 0; n < PHASE_TICKS; n++) begin
                if (burst_left == 0) begin
                    if ($urandom_range(0, 3) != 0) begin
                        pause_ticks($urandom_range(1, 12));
                    end
                    burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(60, 150)
                                                             : $urandom_range(1, 30);
                end
                pick = $urandom_range(0, 99);
                has_req = (pick < req_pct);
                if (has_req && $urandom_range(0, 99) < 85) begin
                    flr = t_floor'($urandom_range(1, top_now));
                end else begin
                    flr = t_floor'($urandom_range(0, 15));
                end
                send_tick(has_req, flr);
                burst_left--;
            end
            drain_results();
        end

        $display("Run covered %0d ticks over %0d register settings: %0d requests taken, %0d arrivals.",
                 results_seen, settings_written, requests_taken, arrivals);
        if (fail_count == 0) begin
            $display("elevator_door_and_travel_controller verification clean");
        end else begin
            $display("elevator_door_and_travel_controller verification failed");
        end
        $finish;
    end

    // The result side mixes always-ready stretches, random stalls and a fixed pattern,
    // and twice refuses results for a long stretch so that the input side backs up.
    initial begin : receiver
        int mode;
        int seg;
        int hold_offs;
        hold_offs = 0;
        forever begin
            if (hold_offs < 2 && results_seen >= 270 + 400 * hold_offs) begin
                hold_offs++;
                repeat (HOLD_OFF_CYCLES) begin
                    @(negedge clk);
                    m_tready <= 1'b0;
                end
            end
            mode = $urandom_range(0, 3);
            seg = $urandom_range(8, 80);
            for (int c = 0; c < seg; c++) begin
                @(negedge clk);
                case (mode)
                    0: m_tready <= 1'b1;
                    1: m_tready <= ($urandom_range(0, 1) == 1);
                    2: m_tready <= ($urandom_range(0, 3) != 0);
                    default: m_tready <= ((c % 4) != 3);
                endcase
            end
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)
                || (cfg_valid && cfg_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= IDLE_LIMIT) begin
            $display("Timeout: no transfer for %0d cycles with %0d results pending.",
                     stall_cycles, pending);
            $display("elevator_door_and_travel_controller verification failed");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

endmodule
